[src/msort_pkg.sv]
// ----------------------------------------------------------------------------
// msort_pkg
// Shared types and constants of the merge sort engine: data width, default
// set size, controller states and the command and status groups that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package msort_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 32;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SORT,
        ST_SETUP,
        ST_MERGE,
        ST_OSETUP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_en;
        logic sort_init;
        logic run_setup;
        logic merge;
        logic next_run;
        logic next_pass;
        logic out_init;
        logic out_run;
    } cmd_t;

    typedef struct packed {
        logic in_close;
        logic one_elem;
        logic elem_last;
        logic run_last;
        logic pass_last;
        logic out_done;
    } stat_t;

endpackage

[src/msort_ram.sv]
// ----------------------------------------------------------------------------
// msort_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module msort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

[src/msort_dp.sv]
// ----------------------------------------------------------------------------
// msort_dp
// Datapath: element and scratch stores, run pointers, key compare and the
// output register. Acts on commands from the controller, reports status.
// ----------------------------------------------------------------------------
module msort_dp #(
    parameter int DEPTH = msort_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  msort_pkg::cmd_t               cmd,
    output msort_pkg::stat_t              stat,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [msort_pkg::DATA_W-1:0]  s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [msort_pkg::DATA_W-1:0]  m_tdata,
    output logic                          m_tlast
);

    import msort_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     w_reg, w_next;
    logic [CW-1:0]     lo_reg, lo_next;
    logic [CW-1:0]     mid_reg, mid_next;
    logic [CW-1:0]     hi_reg, hi_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [CW-1:0]     o_reg, o_next;
    logic              src_sel_reg, src_sel_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_last_reg, out_last_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;

    logic [CW:0]       w_dbl, lo_w, lo_2w;
    logic [CW-1:0]     mid_calc, hi_calc;
    logic              in_acc, take_left, out_load, o_last;
    logic [DATA_W-1:0] a_rd0, a_rd1, b_rd0, b_rd1, d0, d1, wr_data;
    logic              a_we, b_we;
    logic [AW-1:0]     a_waddr, rd0_addr, rd1_addr;

    assign in_acc   = s_tvalid && cmd.load_en;
    assign s_tready = cmd.load_en;

    assign w_dbl    = {w_reg, 1'b0};
    assign lo_w     = {1'b0, lo_reg} + {1'b0, w_reg};
    assign lo_2w    = {1'b0, lo_reg} + w_dbl;
    assign mid_calc = (lo_w < {1'b0, count_reg}) ? lo_w[CW-1:0] : count_reg;
    assign hi_calc  = (lo_2w < {1'b0, count_reg}) ? lo_2w[CW-1:0] : count_reg;

    assign d0 = src_sel_reg ? b_rd0 : a_rd0;
    assign d1 = src_sel_reg ? b_rd1 : a_rd1;

    assign take_left = (i_reg < mid_reg)
                       && ((j_reg >= hi_reg) || ($signed(d0) <= $signed(d1)));
    assign wr_data   = take_left ? d0 : d1;

    assign out_load = cmd.out_run && (!out_valid_reg || m_tready);
    assign o_last   = (o_reg + CW'(1)) == count_reg;

    always_comb
    begin
        count_next     = count_reg;
        w_next         = w_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        o_next         = o_reg;
        src_sel_next   = src_sel_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_data_next  = out_data_reg;

        if (in_acc)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.sort_init)
        begin
            w_next       = CW'(1);
            lo_next      = '0;
            src_sel_next = 1'b0;
        end
        if (cmd.run_setup)
        begin
            mid_next = mid_calc;
            hi_next  = hi_calc;
            i_next   = lo_reg;
            j_next   = mid_calc;
            k_next   = lo_reg;
        end
        if (cmd.merge)
        begin
            if (take_left)
            begin
                i_next = i_reg + CW'(1);
            end
            else
            begin
                j_next = j_reg + CW'(1);
            end
            k_next = k_reg + CW'(1);
        end
        if (cmd.next_run)
        begin
            lo_next = hi_reg;
        end
        if (cmd.next_pass)
        begin
            lo_next      = '0;
            w_next       = w_dbl[CW-1:0];
            src_sel_next = !src_sel_reg;
        end
        if (cmd.out_init)
        begin
            o_next = '0;
        end
        if (out_load)
        begin
            o_next         = o_reg + CW'(1);
            out_valid_next = 1'b1;
            out_data_next  = d0;
            out_last_next  = o_last;
            if (o_last)
            begin
                count_next = '0;
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            w_reg         <= '0;
            lo_reg        <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            o_reg         <= '0;
            src_sel_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            w_reg         <= w_next;
            lo_reg        <= lo_next;
            mid_reg       <= mid_next;
            hi_reg        <= hi_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            o_reg         <= o_next;
            src_sel_reg   <= src_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // Read addresses follow the next pointers so registered data matches the pointers.
    assign rd0_addr = (cmd.out_init || cmd.out_run) ? o_next[AW-1:0] : i_next[AW-1:0];
    assign rd1_addr = j_next[AW-1:0];

    assign a_we    = in_acc || (cmd.merge && src_sel_reg);
    assign a_waddr = in_acc ? count_reg[AW-1:0] : k_reg[AW-1:0];
    assign b_we    = cmd.merge && !src_sel_reg;

    msort_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_elem_ram (
        .clk    (clk),
        .we     (a_we),
        .waddr  (a_waddr),
        .wdata  (in_acc ? s_tdata : wr_data),
        .raddr0 (rd0_addr),
        .raddr1 (rd1_addr),
        .rdata0 (a_rd0),
        .rdata1 (a_rd1)
    );

    msort_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_scratch_ram (
        .clk    (clk),
        .we     (b_we),
        .waddr  (k_reg[AW-1:0]),
        .wdata  (wr_data),
        .raddr0 (rd0_addr),
        .raddr1 (rd1_addr),
        .rdata0 (b_rd0),
        .rdata1 (b_rd1)
    );

    assign stat.in_close  = in_acc && (s_tlast || ((count_reg + CW'(1)) == CW'(DEPTH)));
    assign stat.one_elem  = count_reg == CW'(1);
    assign stat.elem_last = (k_reg + CW'(1)) == hi_reg;
    assign stat.run_last  = hi_reg == count_reg;
    assign stat.pass_last = w_dbl >= {1'b0, count_reg};
    assign stat.out_done  = out_load && o_last;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count beyond set size");

    a_merge_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge |-> (k_reg < hi_reg) && ((i_reg < mid_reg) || (j_reg < hi_reg)))
        else $error("merge step outside its run");

    a_merge_balance: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge |-> (k_reg - lo_reg) == ((i_reg - lo_reg) + (j_reg - mid_reg)))
        else $error("merge pointers out of step");

    a_pass_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.next_pass |-> stat.run_last && stat.elem_last)
        else $error("pass ended before its last run");
`endif

endmodule

[src/msort_ctrl.sv]
// ----------------------------------------------------------------------------
// msort_ctrl
// Controller: sequences loading, merge passes and output streaming.
// ----------------------------------------------------------------------------
module msort_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  msort_pkg::stat_t  stat,
    output msort_pkg::cmd_t   cmd
);

    import msort_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD:
            begin
                cmd.load_en = 1'b1;
                if (stat.in_close)
                begin
                    state_next = ST_SORT;
                end
            end
            ST_SORT:
            begin
                cmd.sort_init = 1'b1;
                state_next    = stat.one_elem ? ST_OSETUP : ST_SETUP;
            end
            ST_SETUP:
            begin
                cmd.run_setup = 1'b1;
                state_next    = ST_MERGE;
            end
            ST_MERGE:
            begin
                cmd.merge = 1'b1;
                if (stat.elem_last)
                begin
                    if (!stat.run_last)
                    begin
                        cmd.next_run = 1'b1;
                        state_next   = ST_SETUP;
                    end
                    else
                    begin
                        cmd.next_pass = 1'b1;
                        state_next    = stat.pass_last ? ST_OSETUP : ST_SETUP;
                    end
                end
            end
            ST_OSETUP:
            begin
                cmd.out_init = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                cmd.out_run = 1'b1;
                if (stat.out_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_close_to_sort: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) && stat.in_close |=> state_reg == ST_SORT)
        else $error("closed set did not start sorting");

    a_out_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) && stat.out_done |=> state_reg == ST_LOAD)
        else $error("output did not return to loading");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_en, cmd.sort_init, cmd.run_setup, cmd.merge,
                  cmd.out_init, cmd.out_run}))
        else $error("conflicting datapath commands");
`endif

endmodule

[src/merge_sort_engine.sv]
// ----------------------------------------------------------------------------
// merge_sort_engine
// Collects a set of signed 32-bit items and streams them back sorted.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one value per item in s_tdata, s_tlast closes the set.
//   The DEPTH-th item closes the set as well. Loading accepts each item as
//   soon as s_tvalid is high. After the closing item the set is sorted by
//   bottom-up merge passes that ping-pong between two RAMs: ceil(log2(n))
//   passes with one setup state per run, one element merged per cycle
//   through the two read ports of the source RAM. Then a setup state primes
//   the read and the sorted items leave on m_* at one per cycle while the
//   receiver is ready; m_tlast marks the final one. For n = 32 the sort
//   takes 5 passes with 31 run setups in all.
//   s_tready is high only while loading. When the receiver stalls, the
//   output register holds its item and the read pointer waits.
//   Reset returns the block to loading with an empty set and no pending
//   result; store contents are not cleared.
// ----------------------------------------------------------------------------
module merge_sort_engine #(
    parameter int DEPTH = msort_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [msort_pkg::DATA_W-1:0]  s_tdata,   // [31:0] value
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [msort_pkg::DATA_W-1:0]  m_tdata,   // [31:0] sorted_value
    output logic                          m_tlast
);

    import msort_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    msort_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    msort_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for merge_sort_engine. A short table of fixed sets
// (single values at the extremes, a reversed pair, equal keys, a descending
// run) is followed by random sets of 1 to 32 values. Some random sets end on
// tlast and some are closed by size. A sorting model in the bench predicts
// the random bursts. Source and sink idle and stall at random in several
// phases, and every output item is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    import msort_pkg::*;

    localparam int SET_MAX   = DEPTH_DEF;
    localparam int RAND_ITEMS = 250;

    localparam logic [DATA_W-1:0] V_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] V_MIN  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] V_ZERO = 32'h0000_0000;
    localparam logic [DATA_W-1:0] V_NEG1 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
        logic [1:0]        pin_n;
        logic [DATA_W-1:0] pin0;
        logic [DATA_W-1:0] pin1;
    } stim_row_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              fin;
    } sorted_item_t;

    localparam int DIR_ROWS = 17;

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{V_ZERO,        1'b1, 2'd1, V_ZERO, V_ZERO},
        '{V_MAX,         1'b1, 2'd1, V_MAX,  V_ZERO},
        '{V_MIN,         1'b1, 2'd1, V_MIN,  V_ZERO},
        '{V_NEG1,        1'b1, 2'd1, V_NEG1, V_ZERO},
        '{V_MAX,         1'b0, 2'd0, V_ZERO, V_ZERO},
        '{V_MIN,         1'b1, 2'd2, V_MIN,  V_MAX},
        '{V_NEG1,        1'b0, 2'd0, V_ZERO, V_ZERO},
        '{32'd1,         1'b1, 2'd2, V_NEG1, 32'd1},
        '{32'd5,         1'b0, 2'd0, V_ZERO, V_ZERO},
        '{32'd5,         1'b1, 2'd2, 32'd5,  32'd5},
        '{32'd4,         1'b0, 2'd0, V_ZERO, V_ZERO},
        '{32'd3,         1'b0, 2'd0, V_ZERO, V_ZERO},
        '{32'd2,         1'b0, 2'd0, V_ZERO, V_ZERO},
        '{32'd1,         1'b0, 2'd0, V_ZERO, V_ZERO},
        '{V_ZERO,        1'b1, 2'd0, V_ZERO, V_ZERO},
        '{32'hAAAA_AAAA, 1'b0, 2'd0, V_ZERO, V_ZERO},
        '{32'h5555_5555, 1'b1, 2'd0, V_ZERO, V_ZERO}
    };

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;

    logic signed [DATA_W-1:0] open_set [$];
    sorted_item_t             sorted_q [$];
    int                       err_count     = 0;
    int                       send_idle_pct = 0;
    int                       rcv_stall_pct = 0;

    merge_sort_engine #(
        .DEPTH (SET_MAX)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] value
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [31:0] sorted_value
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic bit stash_item(logic [DATA_W-1:0] value, logic last);
        open_set.push_back(value);
        return last || (open_set.size() == SET_MAX);
    endfunction

    // stable insertion sort of the open set, then queue it as one burst
    function automatic void push_sorted_set();
        logic signed [DATA_W-1:0] keys [$];
        logic signed [DATA_W-1:0] key;
        sorted_item_t             item;
        int                       j;
        keys = open_set;
        for (int i = 1; i < keys.size(); i++)
        begin
            key = keys[i];
            j   = i - 1;
            while (j >= 0 && keys[j] > key)
            begin
                keys[j + 1] = keys[j];
                j--;
            end
            keys[j + 1] = key;
        end
        foreach (keys[k])
        begin
            item.value = keys[k];
            item.fin   = (k == keys.size() - 1);
            sorted_q.push_back(item);
        end
        open_set.delete();
    endfunction

    function automatic void push_pinned_set(stim_row_t row);
        sorted_item_t item;
        item.value = row.pin0;
        item.fin   = (row.pin_n == 2'd1);
        sorted_q.push_back(item);
        if (row.pin_n == 2'd2)
        begin
            item.value = row.pin1;
            item.fin   = 1'b1;
            sorted_q.push_back(item);
        end
        open_set.delete();
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9, 0))
            0:       return V_MIN;
            1:       return V_MAX;
            2:       return $urandom_range(15, 0) - 8;
            3:       return $urandom_range(1, 0) ? V_NEG1 : V_ZERO;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(logic [DATA_W-1:0] value, logic last);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        sorted_item_t want;
        if (m_tvalid && m_tready)
        begin
            if (sorted_q.size() == 0)
            begin
                $display("%0t: unexpected item value %0d last %0b", $time,
                         $signed(m_tdata), m_tlast);
                err_count++;
            end
            else
            begin
                want = sorted_q.pop_front();
                if (m_tdata !== want.value || m_tlast !== want.fin)
                begin
                    $display("%0t: expected value %0d last %0b, got value %0d last %0b",
                             $time, $signed(want.value), want.fin,
                             $signed(m_tdata), m_tlast);
                    err_count++;
                end
            end
        end
        m_tready <= rst_n && ($urandom_range(99, 0) >= rcv_stall_pct);
    end

    initial
    begin
        int               sent;
        int               set_len;
        bit               size_closed;
        logic             last;
        logic [DATA_W-1:0] value;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            send_item(dir_rows[r].value, dir_rows[r].last);
            if (stash_item(dir_rows[r].value, dir_rows[r].last))
            begin
                if (dir_rows[r].pin_n != 2'd0)
                    push_pinned_set(dir_rows[r]);
                else
                    push_sorted_set();
            end
        end

        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            case (sent * 4 / RAND_ITEMS)
                0:       begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
                1:       begin send_idle_pct = 72; rcv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  rcv_stall_pct = 72; end
                default: begin send_idle_pct = 9;  rcv_stall_pct = 9;  end
            endcase
            size_closed = 1'b0;
            case ($urandom_range(9, 0))
                0:       begin set_len = SET_MAX; size_closed = 1'b1; end
                1:       set_len = SET_MAX;
                2:       set_len = 1;
                default: set_len = $urandom_range(12, 2);
            endcase
            for (int k = 0; k < set_len; k++)
            begin
                value = pick_value();
                last  = !size_closed && (k == set_len - 1);
                send_item(value, last);
                sent++;
                if (stash_item(value, last))
                    push_sorted_set();
            end
        end
        s_tvalid <= 1'b0;

        while (sorted_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
